### sv/kmm_pkg.sv
`timescale 1ns / 1ps

package kmm_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_STATISTICS_MODE = 3'd0;
   localparam logic [2:0] REG_PARTICLE_COUNT  = 3'd1;
   localparam logic [2:0] REG_COEF_X          = 3'd2;
   localparam logic [2:0] REG_COEF_Y          = 3'd3;
   localparam logic [2:0] REG_COEF_Z          = 3'd4;

   // Statistics modes; the undefined code behaves as distinguishable.
   localparam logic [1:0] MODE_DISTINGUISHABLE = 2'd0;
   localparam logic [1:0] MODE_BOSON           = 2'd1;
   localparam logic [1:0] MODE_FERMION         = 2'd2;
   localparam logic [1:0] MODE_UNDEFINED       = 2'd3;

   // Result outcome codes.
   localparam logic [1:0] OUT_ACCEPT    = 2'd0;
   localparam logic [1:0] OUT_EXCLUSION = 2'd1;
   localparam logic [1:0] OUT_REJECT    = 2'd2;
   localparam logic [1:0] OUT_RANGE     = 2'd3;

   // Field widths of the streams.
   localparam int COEF_BITS  = 24;
   localparam int DRAW_BITS  = 16;
   localparam int WEIGHT_BITS = 32;

   // Controls of one ring cell.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

### sv/kspace_metropolis_move_top.sv
`timescale 1ns / 1ps

// Metropolis move on a table of particle momenta.
// The req_ stream carries one proposed move per request: a particle, a
// dimension, a step direction and a uniform draw. The rsp_ stream returns
// one result per request: accepted flag, outcome, particle echo and the
// component value after the step. The csr_ port writes the mode, the
// particle count and the three coefficients; it is always ready.
// The table lives in a ring of MAX_PARTICLES cells that rotates one entry
// per cycle while the mover is fetched or compared. A request takes one
// full rotation to fetch the mover and, in boson and fermion mode, a
// second rotation to compare it with every particle in use, then the
// check, wait, product and compare states for weight, products and
// decision; an unused particle or bad dimension goes straight to the
// result. One request is handled at a time. A stalled receiver holds the
// result in the output register; a finished request waits for it before
// the next is taken. Reset clears the table to zero, sets the count to one,
// the mode and coefficients to zero, and leaves the sequencer idle with no result.

module kspace_metropolis_move_top #(
   parameter int MAX_PARTICLES       = 64,
   parameter int COORD_BITS          = 8,
   parameter int FRACTION_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // particle_index[5:0], dimension[7:6], step_up[8], uniform_draw[24:9]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], outcome[2:1], moved_particle[8:3], component_value[16:9]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int ENB   = 3 * CB;
   localparam int IDXW  = $clog2(MAX_PARTICLES);
   localparam int NW    = $clog2(MAX_PARTICLES + 1);
   localparam int DW    = CB + 2;
   localparam int EBITS = kmm_pkg::COEF_BITS + 1 + DW;
   localparam int PW    = kmm_pkg::WEIGHT_BITS + NW + 1;
   localparam logic signed [CB-1:0] VMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] VMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [DW-1:0] ONE  = 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_CHECK, ST_SCAN, ST_WAIT, ST_PROD, ST_CMP, ST_DONE
   } state_type;

   state_type state_ff;
   logic [1:0]              mode_ff;
   logic [6:0]              count_ff;
   logic [23:0]             coef_ff [3];
   logic [5:0]              p_ff;
   logic [1:0]              dim_ff;
   logic                    up_ff;
   logic [15:0]             u_ff;
   logic [IDXW-1:0]         t_ff;
   logic [ENB-1:0]          mover_ff;
   logic [ENB-1:0]          tgt_ff;
   logic signed [EBITS-1:0] e_ff;
   logic [NW-1:0]           nnew_ff;
   logic [NW-1:0]           nold_ff;
   logic                    excl_ff;
   logic [PW-1:0]           lhs_ff;
   logic [PW-1:0]           rhs_ff;
   logic                    acc_ff;
   logic [1:0]              outc_ff;
   logic [7:0]              val_ff;
   logic                    rsp_tvalid_ff;
   logic [23:0]             rsp_tdata_ff;

   logic [ENB-1:0]                   cell_q [MAX_PARTICLES];
   kmm_pkg::cell_ctl_type            cell_ctl [MAX_PARTICLES];
   logic [ENB-1:0]                   head;
   logic [kmm_pkg::WEIGHT_BITS-1:0]  w;

   logic signed [CB-1:0]    old_v;
   logic signed [CB-1:0]    new_v;
   logic                    leaving;
   logic [ENB-1:0]          tgt_in;
   logic signed [DW-1:0]    dbl;
   logic signed [DW-1:0]    diff;
   logic [23:0]             coef_sel;
   logic signed [EBITS-1:0] e_in;
   logic                    in_use;
   logic                    last_t;
   logic                    res_load;
   logic                    shift_on;
   logic                    req_ok;
   logic [5:0]              req_p;
   logic [1:0]              req_dim;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign head       = cell_q[0];
   assign req_p      = req_tdata[5:0];
   assign req_dim    = req_tdata[7:6];

   // Datapath of the proposal: old and new component, target state, exponent.
   always_comb begin
      old_v    = mover_ff[dim_ff*CB +: CB];
      new_v    = up_ff ? old_v + CB'(1) : old_v - CB'(1);
      leaving  = up_ff ? (old_v == VMAX) : (old_v == VMIN);
      tgt_in   = mover_ff;
      tgt_in[dim_ff*CB +: CB] = new_v;
      dbl      = DW'(old_v) <<< 1;
      diff     = up_ff ? -(dbl + ONE) : dbl - ONE;
      coef_sel = (dim_ff < 2'd3) ? coef_ff[dim_ff] : '0;
      e_in     = $signed(EBITS'({1'b0, coef_sel})) * EBITS'(diff);
      in_use   = 32'(t_ff) < 32'(count_ff);
      last_t   = (t_ff == IDXW'(MAX_PARTICLES - 1));
      res_load = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
      shift_on = (state_ff == ST_FETCH) || (state_ff == ST_SCAN);
      req_ok   = (32'(req_p) < 32'(count_ff)) && (32'(req_p) < MAX_PARTICLES) &&
                 (req_dim != 2'd3);
   end

   // Ring of particle cells; the mover is written back when aligned.
   for (genvar j = 0; j < MAX_PARTICLES; j++) begin : g_cell
      assign cell_ctl[j].shift = shift_on;
      assign cell_ctl[j].load  = res_load && acc_ff && (32'(p_ff) == j);
      kmm_cell #(.ENTRY_BITS(ENB)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl[j]),
         .shift_in  (cell_q[(j + 1) % MAX_PARTICLES]),
         .load_data (tgt_ff),
         .entry_ff  (cell_q[j])
      );
   end

   kmm_weight #(.EBITS(EBITS), .FTB(FRACTION_TABLE_BITS)) u_weight (
      .clock (clock),
      .e_in  (e_ff),
      .w_ff  (w)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         count_ff <= 7'd1;
         coef_ff  <= '{default: '0};
      end else if (csr_valid) begin
         case (csr_index)
            kmm_pkg::REG_STATISTICS_MODE: mode_ff    <= csr_data[1:0];
            kmm_pkg::REG_PARTICLE_COUNT:  count_ff   <= csr_data[6:0];
            kmm_pkg::REG_COEF_X:          coef_ff[0] <= csr_data;
            kmm_pkg::REG_COEF_Y:          coef_ff[1] <= csr_data;
            kmm_pkg::REG_COEF_Z:          coef_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer of one request and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         t_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !res_load) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  p_ff   <= req_p;
                  dim_ff <= req_dim;
                  up_ff  <= req_tdata[8];
                  u_ff   <= req_tdata[24:9];
                  acc_ff <= 1'b0;
                  t_ff   <= '0;
                  if (req_ok) begin
                     state_ff <= ST_FETCH;
                  end else begin
                     outc_ff  <= kmm_pkg::OUT_RANGE;
                     val_ff   <= '0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_FETCH: begin
               if (32'(t_ff) == 32'(p_ff)) mover_ff <= head;
               t_ff <= last_t ? '0 : t_ff + 1'b1;
               if (last_t) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               tgt_ff  <= tgt_in;
               e_ff    <= e_in;
               excl_ff <= 1'b0;
               val_ff  <= 8'(32'(old_v));
               if (leaving) begin
                  outc_ff  <= kmm_pkg::OUT_RANGE;
                  state_ff <= ST_DONE;
               end else if (mode_ff == kmm_pkg::MODE_BOSON ||
                            mode_ff == kmm_pkg::MODE_FERMION) begin
                  nnew_ff  <= '0;
                  nold_ff  <= (mode_ff == kmm_pkg::MODE_BOSON) ? '0 : NW'(1);
                  state_ff <= ST_SCAN;
               end else begin
                  nnew_ff  <= '0;
                  nold_ff  <= NW'(1);
                  state_ff <= ST_WAIT;
               end
            end
            ST_SCAN: begin
               if (in_use) begin
                  if (mode_ff == kmm_pkg::MODE_FERMION) begin
                     if (32'(t_ff) != 32'(p_ff) && head == tgt_ff) excl_ff <= 1'b1;
                  end else begin
                     if (head == tgt_ff)   nnew_ff <= nnew_ff + 1'b1;
                     if (head == mover_ff) nold_ff <= nold_ff + 1'b1;
                  end
               end
               t_ff <= last_t ? '0 : t_ff + 1'b1;
               if (last_t) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (excl_ff) begin
                  outc_ff  <= kmm_pkg::OUT_EXCLUSION;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               lhs_ff   <= PW'(w) * (PW'(nnew_ff) + PW'(1));
               rhs_ff   <= PW'(u_ff) * PW'(nold_ff);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (lhs_ff > rhs_ff) begin
                  acc_ff  <= 1'b1;
                  outc_ff <= kmm_pkg::OUT_ACCEPT;
                  val_ff  <= 8'(32'(tgt_ff[dim_ff*CB +: CB] ^ {CB{1'b0}} ) ^
                                ((32'(new_v) ^ 32'(tgt_ff[dim_ff*CB +: CB]))));
               end else begin
                  outc_ff <= kmm_pkg::OUT_REJECT;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (res_load) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {7'd0, val_ff, p_ff, outc_ff, acc_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The ring is aligned whenever no request is in work.
   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (t_ff == '0))
      else $error("ring not aligned while idle");

   // A taken request closes the input until its result is loaded.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // The accepted flag agrees with the outcome code.
   a_flag_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == kmm_pkg::OUT_ACCEPT)))
      else $error("accepted flag disagrees with outcome");

   // A table write happens only together with a new result.
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      (res_load && acc_ff) |=> (rsp_tvalid && rsp_tdata[0]))
      else $error("table write without accepted result");

endmodule

### sv/kmm_cell.sv
`timescale 1ns / 1ps

module kmm_cell #(
   parameter int ENTRY_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kmm_pkg::cell_ctl_type     ctl,
   input  logic [ENTRY_BITS-1:0]     shift_in,
   input  logic [ENTRY_BITS-1:0]     load_data,
   output logic [ENTRY_BITS-1:0]     entry_ff
);

   // One particle entry: loaded by an update or passed along the ring.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (ctl.load) begin
         entry_ff <= load_data;
      end else if (ctl.shift) begin
         entry_ff <= shift_in;
      end
   end

endmodule

### sv/kmm_weight.sv
`timescale 1ns / 1ps

module kmm_weight #(
   parameter int EBITS = 35,
   parameter int FTB   = 8
) (
   input  logic                                  clock,
   input  logic signed [EBITS-1:0]               e_in,
   output logic [kmm_pkg::WEIGHT_BITS-1:0]       w_ff
);

   localparam int FT_SIZE = 1 << FTB;
   localparam int IPW     = EBITS - 16;

   typedef logic [31:0] tab_type [FT_SIZE];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bv;
      v   = v_in;
      res = '0;
      bv  = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= res + bv) begin
            v   = v - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // Table of 2^(k/FT_SIZE) in Q16, built from repeated square roots of two.
   function automatic tab_type build_tab();
      logic [63:0] roots [FTB+1];
      logic [63:0] acc;
      tab_type     t;
      roots[0] = 64'd2 << 30;
      for (int j = 1; j <= FTB; j++) roots[j] = isqrt64(roots[j-1] << 30);
      for (int k = 0; k < FT_SIZE; k++) begin
         acc = 64'd1 << 30;
         for (int b = 0; b < FTB; b++) begin
            if (((k >> b) & 1) != 0) acc = (acc * roots[FTB-b]) >> 30;
         end
         t[k] = 32'(acc >> 14);
      end
      return t;
   endfunction

   localparam tab_type EXP_TAB = build_tab();

   logic signed [IPW-1:0] ip;
   logic [IPW:0]          negm;
   logic [FTB-1:0]        k;
   logic [31:0]           tv;
   logic                  sat;
   logic [31:0]           w_in;

   // Split the exponent, look up the fraction and shift by the integer part; large exponents saturate at 2^15.
   always_comb begin
      ip   = IPW'(e_in >>> 16);
      negm = -{ip[IPW-1], ip};
      k    = e_in[15 -: FTB];
      tv   = EXP_TAB[k];
      sat  = e_in >= $signed(EBITS'(983040));
      if (sat) begin
         w_in = 32'd1 << 31;
      end else if (!ip[IPW-1]) begin
         w_in = tv << ip[3:0];
      end else if (negm >= (IPW+1)'(32)) begin
         w_in = '0;
      end else begin
         w_in = tv >> negm[4:0];
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int NPART = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] draw;
      logic        up;
      logic [1:0]  dim;
      logic [5:0]  particle;
   } move_req_type;

   typedef struct packed {
      logic [7:0]  value;
      logic [5:0]  particle;
      logic [1:0]  outcome;
      logic        accepted;
   } move_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   kspace_metropolis_move_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block state used to predict each outcome.
   logic signed [7:0] mom [NPART][3];
   logic [1:0]  stat_mode;
   logic [6:0]  pcount;
   logic [23:0] coef [3];
   logic [31:0] exp_frac [256];

   move_rsp_type expected_moves [$];
   int  errors = 0;
   int  moves_sent = 0;
   int  rsp_seen = 0;
   int  idle_gap_pct = 0;
   int  stall_pct = 0;
   int  quiet_cycles = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic build_exp_table();
      logic [63:0] roots [9];
      logic [63:0] acc;
      roots[0] = 64'd2 << 30;
      for (int j = 1; j <= 8; j++) roots[j] = int_sqrt(roots[j-1] << 30);
      for (int k = 0; k < 256; k++) begin
         acc = 64'd1 << 30;
         for (int b = 0; b < 8; b++)
            if (k[b]) acc = (acc * roots[8-b]) >> 30;
         exp_frac[k] = acc[45:14];
      end
   endtask

   // Weight 2^e in Q16, saturated at 2^15.
   function automatic logic [63:0] weight_q16(longint e);
      longint ip;
      longint fr;
      logic [63:0] t;
      if (e >= 64'sd15 * 65536) return 64'd1 << 31;
      ip = e >>> 16;
      fr = e - ip * 65536;
      t = exp_frac[fr[15:8]];
      if (ip >= 0) return t << ip;
      if (-ip >= 32) return 0;
      return t >> (-ip);
   endfunction

   function automatic move_rsp_type predict_move(move_req_type m);
      move_rsp_type r;
      int cnt;
      int oldv, newv;
      longint e;
      logic [63:0] nnew, nold;
      logic [1:0] md;
      logic at_new, at_old, hit;
      r = '0;
      r.particle = m.particle;
      cnt = (pcount < NPART) ? pcount : NPART;
      md = (stat_mode == kmm_pkg::MODE_UNDEFINED) ? kmm_pkg::MODE_DISTINGUISHABLE
                                                   : stat_mode;
      if (m.particle >= cnt || m.dim > 2) begin
         r.outcome = kmm_pkg::OUT_RANGE;
         return r;
      end
      oldv = mom[m.particle][m.dim];
      newv = m.up ? oldv + 1 : oldv - 1;
      if (newv < -128 || newv > 127) begin
         r.outcome = kmm_pkg::OUT_RANGE;
         r.value = oldv[7:0];
         return r;
      end
      nnew = 0;
      nold = 1;
      if (md == kmm_pkg::MODE_FERMION) begin
         for (int i = 0; i < cnt; i++) begin
            if (i == m.particle) continue;
            hit = 1'b1;
            for (int c = 0; c < 3; c++)
               if (mom[i][c] != ((c == m.dim) ? newv : mom[m.particle][c])) hit = 1'b0;
            if (hit) begin
               r.outcome = kmm_pkg::OUT_EXCLUSION;
               r.value = oldv[7:0];
               return r;
            end
         end
      end
      if (md == kmm_pkg::MODE_BOSON) begin
         nold = 0;
         for (int i = 0; i < cnt; i++) begin
            at_new = 1'b1;
            at_old = 1'b1;
            for (int c = 0; c < 3; c++) begin
               if (mom[i][c] != ((c == m.dim) ? newv : mom[m.particle][c])) at_new = 1'b0;
               if (mom[i][c] != mom[m.particle][c]) at_old = 1'b0;
            end
            if (at_new) nnew++;
            if (at_old) nold++;
         end
      end
      e = longint'(coef[m.dim]) * (longint'(oldv * oldv) - longint'(newv * newv));
      if (weight_q16(e) * (nnew + 1) > 64'(m.draw) * nold) begin
         mom[m.particle][m.dim] = newv[7:0];
         r.accepted = 1'b1;
         r.outcome = kmm_pkg::OUT_ACCEPT;
         r.value = newv[7:0];
      end else begin
         r.outcome = kmm_pkg::OUT_REJECT;
         r.value = oldv[7:0];
      end
      return r;
   endfunction

   // Send one proposed move as a request and queue its prediction.
   // The valid line stays up after a handshake so that back-to-back
   // requests need no extra edge; an idle gap or a drain lowers it.
   task automatic send_move(logic [5:0] p, logic [1:0] d, logic up, logic [15:0] u);
      move_req_type m;
      m = '{draw: u, up: up, dim: d, particle: p};
      while (idle_gap_pct > 0 && $urandom_range(99) < idle_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {7'd0, m};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_moves.push_back(predict_move(m));
      moves_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) @(negedge clock);
      repeat (2 * NPART + 20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         kmm_pkg::REG_STATISTICS_MODE: stat_mode = val[1:0];
         kmm_pkg::REG_PARTICLE_COUNT:  pcount = val[6:0];
         kmm_pkg::REG_COEF_X:          coef[0] = val;
         kmm_pkg::REG_COEF_Y:          coef[1] = val;
         kmm_pkg::REG_COEF_Z:          coef[2] = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(logic [1:0] md, logic [6:0] cnt,
                             logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
      drain();
      write_reg(kmm_pkg::REG_STATISTICS_MODE, {22'd0, md});
      write_reg(kmm_pkg::REG_PARTICLE_COUNT, {17'd0, cnt});
      write_reg(kmm_pkg::REG_COEF_X, cx);
      write_reg(kmm_pkg::REG_COEF_Y, cy);
      write_reg(kmm_pkg::REG_COEF_Z, cz);
      csr_valid <= 1'b0;
   endtask

   // Directed cases: range limits, unused particle, bad dimension,
   // exclusion and boson counting.
   task automatic test_directed();
      set_config(kmm_pkg::MODE_DISTINGUISHABLE, 7'd4, 24'd0, 24'hFFFFFF, 24'h010000);
      send_move(6'd0, 2'd0, 1'b1, 16'hFFFF);
      send_move(6'd63, 2'd0, 1'b1, 16'd0);
      send_move(6'd1, 2'd3, 1'b0, 16'd0);
      send_move(6'd1, 2'd1, 1'b1, 16'hFFFF);
      send_move(6'd1, 2'd1, 1'b0, 16'h0000);
      send_move(6'd2, 2'd2, 1'b1, 16'h8000);
      send_move(6'd2, 2'd2, 1'b0, 16'h7FFF);
      for (int i = 0; i < 130; i++) send_move(6'd3, 2'd0, 1'b1, 16'd0);
      for (int i = 0; i < 3; i++) send_move(6'd3, 2'd0, 1'b0, 16'hFFFF);
      set_config(kmm_pkg::MODE_UNDEFINED, 7'd127, 24'd0, 24'd0, 24'd0);
      for (int i = 0; i < 260; i++) send_move(6'd5, 2'd2, 1'b0, 16'd0);
      set_config(kmm_pkg::MODE_FERMION, 7'd3, 24'd0, 24'd0, 24'd0);
      send_move(6'd1, 2'd0, 1'b1, 16'd0);
      send_move(6'd0, 2'd0, 1'b1, 16'd0);
      send_move(6'd2, 2'd1, 1'b0, 16'd0);
      set_config(kmm_pkg::MODE_BOSON, 7'd3, 24'h000800, 24'h000800, 24'h000800);
      send_move(6'd0, 2'd1, 1'b1, 16'hFFFF);
      send_move(6'd1, 2'd1, 1'b1, 16'hC000);
   endtask

   task automatic random_moves(int n, int cnt);
      logic [5:0] p;
      for (int i = 0; i < n; i++) begin
         p = ($urandom_range(15) == 0) ? 6'($urandom) : 6'($urandom_range(cnt - 1));
         send_move(p, ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                   1'($urandom), 16'($urandom));
      end
   endtask

   // Random moves under each statistics mode with varied coefficients.
   task automatic test_random_phase(int phase, int n);
      int cnt;
      logic [1:0] md;
      case (phase % 4)
         0: begin idle_gap_pct = 0;  stall_pct = 0;  end
         1: begin idle_gap_pct = 57; stall_pct = 0;  end
         2: begin idle_gap_pct = 0;  stall_pct = 57; end
         default: begin idle_gap_pct = 20; stall_pct = 20; end
      endcase
      md = 2'(phase % 4);
      cnt = (phase % 5 == 0) ? 64 : $urandom_range(2, 12);
      set_config(md, (phase == 7) ? 7'd100 : 7'(cnt),
                 24'($urandom_range(24'h040000)), 24'($urandom) & 24'h00FFFF,
                 (phase % 3 == 0) ? 24'hFFFFFF : 24'($urandom_range(24'h004000)));
      random_moves(n, cnt);
   endtask

   // Result checker.
   always @(posedge clock) begin
      move_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[16:0];
         rsp_seen++;
         if (expected_moves.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
         end else begin
            want = expected_moves.pop_front();
            if (got.accepted !== want.accepted) begin
               $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
               errors++;
            end
            if (got.outcome !== want.outcome) begin
               $error("outcome: expected %0d actual %0d", want.outcome, got.outcome);
               errors++;
            end
            if (got.particle !== want.particle) begin
               $error("moved_particle: expected %0d actual %0d", want.particle,
                      got.particle);
               errors++;
            end
            if (got.value !== want.value) begin
               $error("component_value: expected %0d actual %0d",
                      $signed(want.value), $signed(got.value));
               errors++;
            end
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock)
      rsp_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else if (req_tvalid || expected_moves.size() != 0)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("kspace_metropolis_move_top test failed");
         $finish;
      end
   end

   initial begin
      build_exp_table();
      for (int i = 0; i < NPART; i++)
         for (int c = 0; c < 3; c++) mom[i][c] = '0;
      stat_mode = '0;
      pcount = 7'd1;
      coef[0] = '0;
      coef[1] = '0;
      coef[2] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      for (int ph = 0; ph < 12; ph++) test_random_phase(ph, 110);
      drain();
      $display("Covered %0d requests and %0d results over all statistics modes,",
               moves_sent, rsp_seen);
      $display("range edges, exclusion, saturation and four handshake pressure mixes.");
      if (errors == 0 && expected_moves.size() == 0) begin
         $display("kspace_metropolis_move_top test passed");
      end else begin
         $display("kspace_metropolis_move_top test failed");
      end
      $finish;
   end

endmodule
